// ===== src/assert_macros.svh =====
// assertion macros used by substring_search.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// implication checked in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst_n, trig, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_NEXT(label, clk, rst_n, trig, expr, msg)
`endif

`endif

// ===== src/ss_pkg.sv =====
// types and constants of the substring search block
package ss_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int TEXT_MAX    = 65535;

    localparam int IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
    localparam int CNT_W  = $clog2(TEXT_MAX + 2);
    localparam int POS_W  = 16;
    localparam int WIDE_W = (CNT_W > POS_W) ? CNT_W : POS_W + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int PLEN_W     = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAT_LOW  = 2'd0,
        REG_PAT_HIGH = 2'd1,
        REG_PAT_LEN  = 2'd2,
        REG_START    = 2'd3
    } cfg_reg_t;

    typedef logic [PATTERN_MAX-1:0][7:0] pattern_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic             match_found;
        logic [POS_W-1:0] match_position;
        logic             length_overflow;
    } out_item_t;

    // control shared by every cell of the window
    typedef struct packed {
        logic             shift_en;
        logic [LEN_W-1:0] len_used;
    } cell_ctl_t;

endpackage

// ===== src/ss_cell.sv =====
// one window cell: holds a text byte and compares the arriving byte with its pattern byte
module ss_cell
    import ss_pkg::*;
(
    input  logic             clk,
    input  cell_ctl_t        ctl,
    input  logic [IDX_W-1:0] cell_idx,
    input  pattern_t         pattern,
    input  logic [7:0]       byte_in,
    output logic [7:0]       byte_out,
    output logic             hit
);

    logic [7:0]       byte_reg;
    logic [7:0]       byte_next;
    logic             active;
    logic [LEN_W-1:0] sel;

    // cell k lines up with pattern byte len-1-k in the window after the shift
    assign active = LEN_W'(cell_idx) < ctl.len_used;
    assign sel    = ctl.len_used - LEN_W'(1) - LEN_W'(cell_idx);
    assign hit    = !active || (byte_in == pattern[sel[IDX_W-1:0]]);

    assign byte_next = ctl.shift_en ? byte_in : byte_reg;
    assign byte_out  = byte_reg;

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

// ===== src/ss_out_buf.sv =====
// two-entry result buffer: output register plus skid register
module ss_out_buf
    import ss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_item_t push_data,
    output logic      can_push,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t out_reg, out_next;
    out_item_t skid_reg, skid_next;

    assign can_push  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_next       = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

// ===== src/substring_search.sv =====
// substring search top level: window cell chain, hit tracking and result buffer
//
//  channel | handshake          | payload                   | direction
//  --------+--------------------+---------------------------+----------
//  in      | in_valid/in_ready  | in_data (in_item_t)       | input
//  out     | out_valid/out_ready| out_data (out_item_t)     | output
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data       | input
//
// one text byte per cycle while in_ready is high: the whole window is compared in the cycle the byte arrives
// the result of a search is registered in the output or skid register in the cycle after its last byte is taken
// in_ready drops only while both result slots (output and skid) are full
// cfg_ready is always high; reset clears the configuration, the search state and the result valid flags
`include "assert_macros.svh"

module substring_search
    import ss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [CNT_W-1:0] TEXT_MAX_C = CNT_W'(TEXT_MAX);

    // configuration registers
    logic [63:0]       pat_low_reg, pat_low_next;
    logic [63:0]       pat_high_reg, pat_high_next;
    logic [PLEN_W-1:0] pat_len_reg, pat_len_next;
    logic [POS_W-1:0]  start_reg, start_next;

    // search state
    logic [CNT_W-1:0]  seen_reg, seen_next;
    logic              hit_valid_reg, hit_valid_next;
    logic [POS_W-1:0]  hit_pos_reg, hit_pos_next;

    logic              accept;
    logic              in_window;
    logic [CNT_W-1:0]  count_new;
    logic [CNT_W-1:0]  seen_after;
    logic [CNT_W-1:0]  match_start;
    logic [LEN_W-1:0]  len_used;
    logic              hit_now;
    logic              all_hit;
    logic              hit_valid_after;
    logic [POS_W-1:0]  hit_pos_after;
    logic              ovf;
    logic [CNT_W-1:0]  text_len;
    logic              can_push;
    out_item_t         result;
    pattern_t          pattern;
    logic [127:0]      pat_all;
    cell_ctl_t         ctl;

    logic [PATTERN_MAX-1:0][7:0] chain;
    logic [PATTERN_MAX-1:0]      hits;

    assign cfg_ready = 1'b1;
    assign in_ready  = can_push;
    assign accept    = in_valid && in_ready;

    // ---------------- configuration writes ----------------
    always_comb
    begin
        pat_low_next  = pat_low_reg;
        pat_high_next = pat_high_reg;
        pat_len_next  = pat_len_reg;
        start_next    = start_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PAT_LOW:  pat_low_next  = cfg_data;
                REG_PAT_HIGH: pat_high_next = cfg_data;
                REG_PAT_LEN:  pat_len_next  = cfg_data[PLEN_W-1:0];
                REG_START:    start_next    = cfg_data[POS_W-1:0];
                default:      ;
            endcase
        end
    end

    // pattern bytes in order, byte 0 lowest
    assign pat_all = {pat_high_reg, pat_low_reg};
    always_comb
    begin
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            pattern[j] = pat_all[8*j +: 8];
        end
    end

    // lengths beyond the window size are clipped
    assign len_used = (pat_len_reg > PLEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                           : pat_len_reg[LEN_W-1:0];

    // bytes past the maximum length never enter the window; the count saturates one above the maximum
    assign in_window = seen_reg < TEXT_MAX_C;
    assign count_new = seen_reg + CNT_W'(1);

    assign ctl.shift_en = accept && in_window;
    assign ctl.len_used = len_used;

    // ---------------- window cell chain ----------------
    assign chain[0] = in_data.text_byte;

    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_cell
        if (k < PATTERN_MAX - 1)
        begin : g_mid
            ss_cell u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .cell_idx (IDX_W'(k)),
                .pattern  (pattern),
                .byte_in  (chain[k]),
                .byte_out (chain[k+1]),
                .hit      (hits[k])
            );
        end
        else
        begin : g_last
            ss_cell u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .cell_idx (IDX_W'(k)),
                .pattern  (pattern),
                .byte_in  (chain[k]),
                .byte_out (),
                .hit      (hits[k])
            );
        end
    end

    assign all_hit = &hits;

    // ---------------- first hit tracking ----------------
    assign match_start = count_new - CNT_W'(len_used);
    assign hit_now = in_window && (len_used != '0) && (count_new >= CNT_W'(len_used))
                     && !hit_valid_reg
                     && (WIDE_W'(match_start) >= WIDE_W'(start_reg)) && all_hit;

    assign hit_valid_after = hit_valid_reg || hit_now;
    assign hit_pos_after   = hit_now ? POS_W'(WIDE_W'(match_start)) : hit_pos_reg;

    always_comb
    begin
        if (in_window)
        begin
            seen_after = count_new;
        end
        else if (seen_reg == TEXT_MAX_C)
        begin
            seen_after = TEXT_MAX_C + CNT_W'(1);
        end
        else
        begin
            seen_after = seen_reg;
        end
    end

    // ---------------- result of a finished search ----------------
    assign ovf      = seen_after > TEXT_MAX_C;
    assign text_len = ovf ? TEXT_MAX_C : seen_after;

    always_comb
    begin
        result.length_overflow = ovf;
        if (len_used == '0)
        begin
            // empty pattern matches at the offset if the text reaches it
            result.match_found    = WIDE_W'(start_reg) <= WIDE_W'(text_len);
            result.match_position = result.match_found ? start_reg : '0;
        end
        else
        begin
            result.match_found    = hit_valid_after;
            result.match_position = hit_valid_after ? hit_pos_after : '0;
        end
    end

    // state clears after the last byte of a search
    always_comb
    begin
        seen_next      = seen_reg;
        hit_valid_next = hit_valid_reg;
        hit_pos_next   = hit_pos_reg;
        if (accept)
        begin
            if (in_data.end_of_text)
            begin
                seen_next      = '0;
                hit_valid_next = 1'b0;
                hit_pos_next   = '0;
            end
            else
            begin
                seen_next      = seen_after;
                hit_valid_next = hit_valid_after;
                hit_pos_next   = hit_pos_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg   <= '0;
            pat_high_reg  <= '0;
            pat_len_reg   <= '0;
            start_reg     <= '0;
            seen_reg      <= '0;
            hit_valid_reg <= 1'b0;
            hit_pos_reg   <= '0;
        end
        else
        begin
            pat_low_reg   <= pat_low_next;
            pat_high_reg  <= pat_high_next;
            pat_len_reg   <= pat_len_next;
            start_reg     <= start_next;
            seen_reg      <= seen_next;
            hit_valid_reg <= hit_valid_next;
            hit_pos_reg   <= hit_pos_next;
        end
    end

    // ---------------- result buffer ----------------
    ss_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && in_data.end_of_text),
        .push_data (result),
        .can_push  (can_push),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // ---------------- assertions ----------------
    `ASSERT_ALWAYS(a_stall_needs_result, clk, rst_n, in_ready || out_valid, "input stalled with no result pending")
    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, seen_reg <= TEXT_MAX_C + CNT_W'(1), "byte count above saturation")
    `ASSERT_ALWAYS(a_hit_before_count, clk, rst_n, !hit_valid_reg || (CNT_W'(hit_pos_reg) < seen_reg), "recorded hit starts beyond bytes seen")
    `ASSERT_NEXT(a_last_gives_result, clk, rst_n, accept && in_data.end_of_text, out_valid, "no result after last byte")
    `ASSERT_NEXT(a_last_clears, clk, rst_n, accept && in_data.end_of_text, (seen_reg == '0) && !hit_valid_reg, "search state not cleared")

endmodule
